FILE: src/wfc_pkg.sv
// package for the waypoint follow controller
// shared types, constants and the cordic angle table; no dependencies
package wfc_pkg;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_POSE = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   localparam logic [1:0] REG_ARRIVE = 2'd0;
   localparam logic [1:0] REG_HTOL   = 2'd1;
   localparam logic [1:0] REG_CRUISE = 2'd2;
   localparam logic [1:0] REG_GAIN   = 2'd3;

   localparam int CW = 40;   // cordic datapath width
   localparam logic signed [CW-1:0] PI_Q16     = 40'sd205887;
   localparam logic signed [CW-1:0] TWO_PI_Q16 = 40'sd411775;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] orient_x;
      logic signed [15:0] orient_y;
      logic signed [15:0] orient_z;
      logic signed [15:0] orient_w;
      logic               plan_end;
   } req_type;

   typedef struct packed {
      logic signed [17:0] linear_speed;
      logic signed [19:0] turn_rate;
      logic               goal_reached;
      logic [7:0]         target_slot;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  index;
      logic [31:0] data;
   } csr_type;

   function automatic logic signed [CW-1:0] atan_entry(input logic [4:0] i);
      logic signed [CW-1:0] r;
      r = '0;
      unique case (i)
         5'd0:  r = 40'sd51472;
         5'd1:  r = 40'sd30385;
         5'd2:  r = 40'sd16055;
         5'd3:  r = 40'sd8150;
         5'd4:  r = 40'sd4091;
         5'd5:  r = 40'sd2047;
         5'd6:  r = 40'sd1024;
         5'd7:  r = 40'sd512;
         5'd8:  r = 40'sd256;
         5'd9:  r = 40'sd128;
         5'd10: r = 40'sd64;
         5'd11: r = 40'sd32;
         5'd12: r = 40'sd16;
         5'd13: r = 40'sd8;
         5'd14: r = 40'sd4;
         5'd15: r = 40'sd2;
         5'd16: r = 40'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

FILE: src/wfc_if.sv
// valid/ready channel interfaces for the waypoint follow controller
// depends on wfc_pkg
interface wfc_req_if;
   logic             valid;
   logic             ready;
   wfc_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface wfc_rsp_if;
   logic             valid;
   logic             ready;
   wfc_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface wfc_csr_if;
   logic             valid;
   logic             ready;
   wfc_pkg::csr_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/wfc_store.sv
// waypoint store: synchronous memory, one write and one registered read port
// depends on nothing
module wfc_store #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [63:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [63:0]   rd_data
);
   logic [63:0] mem [DEPTH];
   logic [63:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: src/wfc_cordic.sv
// iterative vectoring cordic, one rotation per cycle, atan2 in q16
// depends on wfc_pkg
module wfc_cordic #(
   parameter int STEPS = 18
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [wfc_pkg::CW-1:0] y_in,
   input  logic signed [wfc_pkg::CW-1:0] x_in,
   output logic                          done,
   output logic signed [wfc_pkg::CW-1:0] angle
);
   localparam int CW = wfc_pkg::CW;
   localparam int IW = (STEPS > 32) ? 6 : 5;

   logic signed [CW-1:0] x_ff, x_in_v, y_ff, y_in_v, z_ff, z_in;
   logic [IW:0]          i_ff, i_in;
   logic                 busy_ff, busy_in;
   logic signed [CW-1:0] xs, ys, zs;

   always_comb begin
      x_in_v  = x_ff;
      y_in_v  = y_ff;
      z_in    = z_ff;
      i_in    = i_ff;
      busy_in = busy_ff;
      xs = x_ff >>> i_ff[IW-1:0];
      ys = y_ff >>> i_ff[IW-1:0];
      zs = wfc_pkg::atan_entry(i_ff[4:0]);
      if (start) begin
         i_in    = '0;
         busy_in = 1'b1;
         if (x_in == '0 && y_in == '0) begin
            x_in_v = '0; y_in_v = '0; z_in = '0;
            busy_in = 1'b0;
         end else if (x_in < 0) begin
            z_in   = (y_in >= 0) ? wfc_pkg::PI_Q16 : -wfc_pkg::PI_Q16;
            x_in_v = -x_in;
            y_in_v = -y_in;
         end else begin
            z_in = '0; x_in_v = x_in; y_in_v = y_in;
         end
      end else if (busy_ff) begin
         if (y_ff >= 0) begin
            x_in_v = x_ff + ys; y_in_v = y_ff - xs; z_in = z_ff + zs;
         end else begin
            x_in_v = x_ff - ys; y_in_v = y_ff + xs; z_in = z_ff - zs;
         end
         i_in = i_ff + 1'b1;
         if (i_ff == (IW+1)'(STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         i_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         i_ff    <= i_in;
      end
      x_ff <= x_in_v;
      y_ff <= y_in_v;
      z_ff <= z_in;
   end

   assign done  = !busy_ff;
   assign angle = z_ff;
endmodule

FILE: src/waypoint_follow_controller.sv
// waypoint follow controller: top level sequencer around the store and cordic
// depends on wfc_pkg, wfc_if, wfc_store, wfc_cordic
// load writes the store, a plan-ending load also reads the first target; pose runs the
// heading cordic; tick runs the bearing cordic and decides, reading the next target when
// it advances; the iterative cordic does one rotation per cycle; one transaction at a
// time, the next request is taken in the cycle after the response handshake
// synchronous active-high reset clears control state and registers to reset values
// the waypoint store has no reset; only written entries are ever targeted
module waypoint_follow_controller #(
   parameter int MAX_WAYPOINTS = 256,
   parameter int CORDIC_STEPS  = 18
) (
   input  logic         clock,
   input  logic         reset,
   wfc_req_if.sink      req,
   wfc_rsp_if.source    rsp,
   wfc_csr_if.sink      csr
);
   localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
   localparam int PW = AW + 1;
   localparam int CW = wfc_pkg::CW;

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LREAD = 4'd1;  // store read for a freshly armed plan
   localparam logic [3:0] S_LLAT  = 4'd2;
   localparam logic [3:0] S_PCORD = 4'd3;  // heading cordic
   localparam logic [3:0] S_PWAIT = 4'd4;
   localparam logic [3:0] S_TCORD = 4'd5;  // bearing cordic
   localparam logic [3:0] S_TWAIT = 4'd6;
   localparam logic [3:0] S_TERR  = 4'd7;  // wrap error, offset range check
   localparam logic [3:0] S_TMUL  = 4'd8;  // gain multiply, distance squares
   localparam logic [3:0] S_TDEC  = 4'd9;  // decide command
   localparam logic [3:0] S_ARD   = 4'd10; // advance: store read
   localparam logic [3:0] S_OUT   = 4'd11;

   logic [3:0] state_ff, state_in;

   // configuration registers
   logic [15:0] arrive_ff;
   logic [17:0] htol_ff;
   logic [16:0] cruise_ff;
   logic [16:0] gain_ff;

   // follower state
   logic [PW-1:0]       load_ptr_ff, load_ptr_in;
   logic [PW-1:0]       plan_size_ff, plan_size_in;
   logic [PW-1:0]       target_idx_ff, target_idx_in;
   logic signed [31:0]  tgt_x_ff, tgt_y_ff, rob_x_ff, rob_y_ff;
   logic signed [31:0]  tgt_x_in, tgt_y_in, rob_x_in, rob_y_in;
   logic signed [CW-1:0] heading_ff, heading_in;
   logic signed [17:0]  lin_ff, lin_in;
   logic signed [19:0]  turn_ff, turn_in;
   logic                arrived_ff, arrived_in;

   // tick working registers
   logic signed [32:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic signed [CW-1:0] err_ff, err_in;
   logic                near_ff, near_in;
   logic signed [CW+17:0] prod_ff, prod_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // store and cordic hookup
   logic          st_wr;
   logic [AW-1:0] st_waddr, st_raddr;
   logic [63:0]   st_rdata;
   logic                 cd_start, cd_done;
   logic signed [CW-1:0] cd_y, cd_x, cd_angle;

   wfc_pkg::req_type r;
   logic signed [31:0]   p_wz, p_xy, p_yy, p_zz;
   logic signed [CW-1:0] t3, t4;
   logic signed [CW-1:0] err_raw;
   logic signed [33:0]   dx_sq, dy_sq;
   logic [31:0]          arrive_sq;
   logic [65:0]          dist_sq;
   logic signed [37:0]   gain_prod;
   logic signed [CW+17:0] turn_sh;
   logic [PW-1:0]        clamp_idx;

   assign r = req.payload;

   wfc_store #(.DEPTH(MAX_WAYPOINTS), .AW(AW)) u_store (
      .clock  (clock),
      .wr_en  (st_wr),
      .wr_addr(st_waddr),
      .wr_data({r.pos_x, r.pos_y}),
      .rd_addr(st_raddr),
      .rd_data(st_rdata)
   );

   wfc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(cd_start),
      .y_in(cd_y), .x_in(cd_x), .done(cd_done), .angle(cd_angle)
   );

   // quaternion yaw terms at q30, 16x16 products
   assign p_wz = r.orient_w * r.orient_z;
   assign p_xy = r.orient_x * r.orient_y;
   assign p_yy = r.orient_y * r.orient_y;
   assign p_zz = r.orient_z * r.orient_z;
   assign t3 = (CW'(p_wz) + CW'(p_xy)) <<< 1;
   assign t4 = (CW'(1) <<< 30) - ((CW'(p_yy) + CW'(p_zz)) <<< 1);

   // clamp the target index into the store
   assign clamp_idx = (target_idx_ff < PW'(MAX_WAYPOINTS)) ? target_idx_ff
                                                           : PW'(MAX_WAYPOINTS - 1);
   assign st_raddr  = clamp_idx[AW-1:0];
   assign st_waddr  = load_ptr_ff[AW-1:0];

   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr.ready = 1'b1;

   wire req_take = req.valid && req.ready;

   always_comb begin
      err_raw = cd_angle - heading_ff;
      // only used when both offsets are inside one metre
      dx_sq = $signed(dx_ff[16:0]) * $signed(dx_ff[16:0]);
      dy_sq = $signed(dy_ff[16:0]) * $signed(dy_ff[16:0]);
      dist_sq = 66'(dx_sq) + 66'(dy_sq);
      arrive_sq = arrive_ff * arrive_ff;
      // wrapped error stays within 20 bits
      gain_prod = $signed(err_ff[19:0]) * $signed({1'b0, gain_ff});
      turn_sh = prod_ff >>> 16;
   end

   always_comb begin
      state_in      = state_ff;
      load_ptr_in   = load_ptr_ff;
      plan_size_in  = plan_size_ff;
      target_idx_in = target_idx_ff;
      tgt_x_in = tgt_x_ff; tgt_y_in = tgt_y_ff;
      rob_x_in = rob_x_ff; rob_y_in = rob_y_ff;
      heading_in = heading_ff;
      lin_in = lin_ff; turn_in = turn_ff;
      arrived_in = arrived_ff;
      dx_in = dx_ff; dy_in = dy_ff;
      err_in = err_ff; near_in = near_ff;
      prod_in = prod_ff;
      rsp_valid_in = rsp_valid_ff;
      st_wr = 1'b0;
      cd_start = 1'b0;
      cd_y = t3; cd_x = t4;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               unique case (r.opcode)
                  wfc_pkg::OP_LOAD: begin
                     if (load_ptr_ff < PW'(MAX_WAYPOINTS)) begin
                        st_wr = 1'b1;
                     end
                     if (r.plan_end) begin
                        // plan size counts this point unless the store was full
                        plan_size_in = (load_ptr_ff < PW'(MAX_WAYPOINTS))
                                     ? load_ptr_ff + 1'b1 : load_ptr_ff;
                        load_ptr_in  = '0;
                        target_idx_in = (plan_size_in > PW'(1)) ? PW'(1) : '0;
                        arrived_in   = 1'b0;
                        state_in     = S_LREAD;
                     end else begin
                        if (load_ptr_ff < PW'(MAX_WAYPOINTS)) begin
                           load_ptr_in = load_ptr_ff + 1'b1;
                        end
                        state_in = S_OUT;
                     end
                  end
                  wfc_pkg::OP_POSE: begin
                     rob_x_in = r.pos_x;
                     rob_y_in = r.pos_y;
                     cd_start = 1'b1;
                     state_in = S_PCORD;
                  end
                  wfc_pkg::OP_TICK: begin
                     if (plan_size_ff == '0) begin
                        state_in = S_OUT;
                     end else begin
                        dx_in = 33'(tgt_x_ff) - 33'(rob_x_ff);
                        dy_in = 33'(tgt_y_ff) - 33'(rob_y_ff);
                        state_in = S_TCORD;
                     end
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_LREAD: state_in = S_LLAT;  // read issued, data next cycle
         S_LLAT: begin
            tgt_x_in = st_rdata[63:32];
            tgt_y_in = st_rdata[31:0];
            state_in = S_OUT;
         end
         S_PCORD: state_in = S_PWAIT;
         S_PWAIT: begin
            if (cd_done) begin
               heading_in = cd_angle;
               state_in   = S_OUT;
            end
         end
         S_TCORD: begin
            cd_y = CW'(dy_ff);
            cd_x = CW'(dx_ff);
            cd_start = 1'b1;
            state_in = S_TWAIT;
         end
         S_TWAIT: if (cd_done) begin
            state_in = S_TERR;
         end
         S_TERR: begin
            // zero offset keeps the heading, so error is zero
            if (dx_ff == '0 && dy_ff == '0) begin
               err_in = '0;
            end else if (err_raw > wfc_pkg::PI_Q16) begin
               err_in = err_raw - wfc_pkg::TWO_PI_Q16;
            end else if (err_raw < -wfc_pkg::PI_Q16) begin
               err_in = err_raw + wfc_pkg::TWO_PI_Q16;
            end else begin
               err_in = err_raw;
            end
            near_in = (dx_ff > -33'sd65536) && (dx_ff < 33'sd65536)
                   && (dy_ff > -33'sd65536) && (dy_ff < 33'sd65536);
            state_in = S_TMUL;
         end
         S_TMUL: begin
            // narrow values make these squares small
            near_in = near_ff && (dist_sq < 66'(arrive_sq));
            prod_in = (CW+18)'(gain_prod);
            state_in = S_TDEC;
         end
         S_TDEC: begin
            if (near_ff) begin
               lin_in = '0; turn_in = '0;
               if (target_idx_ff + 1'b1 < plan_size_ff) begin
                  target_idx_in = target_idx_ff + 1'b1;
                  state_in = S_ARD;
               end else begin
                  arrived_in = 1'b1;
                  state_in = S_OUT;
               end
            end else if (((err_ff < 0) ? -err_ff : err_ff) > CW'(htol_ff)) begin
               lin_in = '0;
               if (turn_sh > (CW+18)'(524287)) begin
                  turn_in = 20'sd524287;
               end else if (turn_sh < -(CW+18)'(524288)) begin
                  turn_in = -20'sd524288;
               end else begin
                  turn_in = turn_sh[19:0];
               end
               state_in = S_OUT;
            end else begin
               lin_in  = $signed({1'b0, cruise_ff});
               turn_in = err_ff[19:0];
               state_in = S_OUT;
            end
         end
         S_ARD: state_in = S_LLAT;
         S_OUT: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         arrive_ff <= 16'd6554;
         htol_ff   <= 18'd6554;
         cruise_ff <= 17'd13107;
         gain_ff   <= 17'd52429;
         load_ptr_ff <= '0; plan_size_ff <= '0; target_idx_ff <= '0;
         tgt_x_ff <= '0; tgt_y_ff <= '0; rob_x_ff <= '0; rob_y_ff <= '0;
         heading_ff <= '0; lin_ff <= '0; turn_ff <= '0; arrived_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         load_ptr_ff <= load_ptr_in; plan_size_ff <= plan_size_in;
         target_idx_ff <= target_idx_in;
         tgt_x_ff <= tgt_x_in; tgt_y_ff <= tgt_y_in;
         rob_x_ff <= rob_x_in; rob_y_ff <= rob_y_in;
         heading_ff <= heading_in; lin_ff <= lin_in; turn_ff <= turn_in;
         arrived_ff <= arrived_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid) begin
            unique case (csr.payload.index)
               wfc_pkg::REG_ARRIVE: arrive_ff <= csr.payload.data[15:0];
               wfc_pkg::REG_HTOL:   htol_ff   <= csr.payload.data[17:0];
               wfc_pkg::REG_CRUISE: cruise_ff <= csr.payload.data[16:0];
               wfc_pkg::REG_GAIN:   gain_ff   <= csr.payload.data[16:0];
            endcase
         end
      end
      dx_ff <= dx_in; dy_ff <= dy_in;
      err_ff <= err_in; near_ff <= near_in; prod_ff <= prod_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload.linear_speed = lin_ff;
   assign rsp.payload.turn_rate    = turn_ff;
   assign rsp.payload.goal_reached = arrived_ff;
   assign rsp.payload.target_slot  = 8'(target_idx_ff);
endmodule

FILE: src/wfc_checker.sv
// port-level checker for the waypoint follow controller, bound to the top level
// depends on wfc_pkg; the bind depends on waypoint_follow_controller
module wfc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input wfc_pkg::rsp_type rsp_payload
);
   // one transaction in flight: no new request while a response waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while response pending");

   // a response never appears in the cycle right after the request
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid) else $error("response too early");

   // no response right after a reset cycle
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("response valid after reset");

   // stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled response changed");
endmodule

bind waypoint_follow_controller wfc_checker u_wfc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_payload(rsp.payload)
);
